// ===== hw/rtl/fpa_pkg.sv =====
`timescale 1ns / 1ps

package fpa_pkg;

   // default number of fraction bits in a raw value
   localparam int FRACTION_BITS_DEF = 8;

   localparam logic signed [63:0] MAX64 = 64'sd2147483647;
   localparam logic signed [63:0] MIN64 = -64'sd2147483648;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_GT       = 4'd4,
      OP_GE       = 4'd5,
      OP_LT       = 4'd6,
      OP_LE       = 4'd7,
      OP_EQ       = 4'd8,
      OP_NE       = 4'd9,
      OP_MIN      = 4'd10,
      OP_MAX      = 4'd11,
      OP_INC      = 4'd12,
      OP_DEC      = 4'd13,
      OP_FROM_INT = 4'd14,
      OP_TO_INT   = 4'd15
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OVF  = 2'd1,
      ST_DZ   = 2'd2
   } status_type;

   // data that rides along the divide cells
   typedef struct packed {
      op_type      op;
      logic [31:0] value;
      logic        cmp;
      status_type  st;
      logic [63:0] prod;
      logic        neg;
      logic        dz;
   } side_type;

   typedef struct packed {
      logic [31:0] value;
      logic        ovf;
   } sat_type;

   // clamp a wide signed value to the 32-bit range
   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type s;
      s.ovf = 1'b1;
      if (v > MAX64) begin
         s.value = 32'h7FFF_FFFF;
      end else if (v < MIN64) begin
         s.value = 32'h8000_0000;
      end else begin
         s.value = v[31:0];
         s.ovf   = 1'b0;
      end
      return s;
   endfunction

endpackage

// ===== hw/rtl/fpa_prep.sv =====
`timescale 1ns / 1ps

module fpa_prep #(
   parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF,
   parameter int NW            = 32 + FRACTION_BITS
) (
   input  logic                clock,
   input  logic                en,
   input  logic [3:0]          opcode,
   input  logic signed [31:0]  operand_a,
   input  logic signed [31:0]  operand_b,
   output fpa_pkg::side_type   side_ff,
   output logic [NW-1:0]       num_ff,
   output logic [31:0]         den_ff
);

   fpa_pkg::side_type side_in;
   fpa_pkg::sat_type  sat;
   fpa_pkg::op_type   op;
   logic [31:0]       mag_a;
   logic [31:0]       mag_b;

   assign op    = fpa_pkg::op_type'(opcode);
   assign mag_a = operand_a[31] ? 32'(-operand_a) : 32'(operand_a);
   assign mag_b = operand_b[31] ? 32'(-operand_b) : 32'(operand_b);

   // work out every operation that needs no long division
   always_comb begin
      side_in       = '0;
      side_in.op    = op;
      side_in.st    = fpa_pkg::ST_OK;
      side_in.prod  = 64'(64'(operand_a) * 64'(operand_b));
      side_in.neg   = operand_a[31] ^ operand_b[31];
      side_in.dz    = (operand_b == 32'sd0);
      sat           = '0;
      case (op)
         fpa_pkg::OP_ADD:      sat = fpa_pkg::sat32(64'(operand_a) + 64'(operand_b));
         fpa_pkg::OP_SUB:      sat = fpa_pkg::sat32(64'(operand_a) - 64'(operand_b));
         fpa_pkg::OP_INC:      sat = fpa_pkg::sat32(64'(operand_a) + 64'sd1);
         fpa_pkg::OP_DEC:      sat = fpa_pkg::sat32(64'(operand_a) - 64'sd1);
         fpa_pkg::OP_FROM_INT: sat = fpa_pkg::sat32(64'(operand_a) <<< FRACTION_BITS);
         fpa_pkg::OP_TO_INT:   sat.value = 32'(operand_a >>> FRACTION_BITS);
         fpa_pkg::OP_MIN:      sat.value = (operand_a < operand_b) ? operand_a : operand_b;
         fpa_pkg::OP_MAX:      sat.value = (operand_a > operand_b) ? operand_a : operand_b;
         fpa_pkg::OP_GT:       side_in.cmp = (operand_a > operand_b);
         fpa_pkg::OP_GE:       side_in.cmp = (operand_a >= operand_b);
         fpa_pkg::OP_LT:       side_in.cmp = (operand_a < operand_b);
         fpa_pkg::OP_LE:       side_in.cmp = (operand_a <= operand_b);
         fpa_pkg::OP_EQ:       side_in.cmp = (operand_a == operand_b);
         fpa_pkg::OP_NE:       side_in.cmp = (operand_a != operand_b);
         default:              sat = '0;
      endcase
      side_in.value = sat.value;
      if (sat.ovf) begin
         side_in.st = fpa_pkg::ST_OVF;
      end
   end

   // hold the word for the divide cells
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_in;
         num_ff  <= NW'(mag_a) << FRACTION_BITS;
         den_ff  <= mag_b;
      end
   end

endmodule

// ===== hw/rtl/fpa_div_cell.sv =====
`timescale 1ns / 1ps

module fpa_div_cell #(
   parameter int NW  = 40,
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              en,
   input  fpa_pkg::side_type side_d,
   input  logic [NW-1:0]     num_d,
   input  logic [31:0]       den_d,
   input  logic [31:0]       rem_d,
   input  logic [NW-1:0]     quo_d,
   output fpa_pkg::side_type side_ff,
   output logic [NW-1:0]     num_ff,
   output logic [31:0]       den_ff,
   output logic [31:0]       rem_ff,
   output logic [NW-1:0]     quo_ff
);

   logic [32:0] trial;
   logic        fits;

   // bring down one numerator bit and try the divisor
   assign trial = {rem_d, num_d[NW-1-IDX]};
   assign fits  = (trial >= {1'b0, den_d});

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_d;
         num_ff  <= num_d;
         den_ff  <= den_d;
         rem_ff  <= fits ? 32'(trial - {1'b0, den_d}) : trial[31:0];
         quo_ff  <= {quo_d[NW-2:0], fits};
      end
   end

endmodule

// ===== hw/rtl/fpa_final.sv =====
`timescale 1ns / 1ps

module fpa_final #(
   parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF,
   parameter int NW            = 32 + FRACTION_BITS
) (
   input  logic              clock,
   input  logic              en,
   input  fpa_pkg::side_type side_d,
   input  logic [31:0]       den_d,
   input  logic [31:0]       rem_d,
   input  logic [NW-1:0]     quo_d,
   output logic [31:0]       value_ff,
   output logic              cmp_ff,
   output logic [1:0]        st_ff
);

   localparam logic [63:0] HALF = (64'd1 << FRACTION_BITS) >> 1;

   logic signed [63:0] prod;
   logic [63:0]        pmag;
   logic [63:0]        pq;
   logic [NW:0]        dq;
   logic               rnd;
   fpa_pkg::sat_type   mul_sat;
   fpa_pkg::sat_type   div_sat;
   logic [31:0]        value_in;
   fpa_pkg::status_type st_in;

   // scale the product down, nearest with ties away from zero
   assign prod    = $signed(side_d.prod);
   assign pmag    = prod[63] ? 64'(-prod) : 64'(prod);
   assign pq      = (pmag + HALF) >> FRACTION_BITS;
   assign mul_sat = fpa_pkg::sat32(prod[63] ? -$signed(pq) : $signed(pq));

   // round the quotient up when twice the remainder reaches the divisor
   assign rnd     = ({rem_d, 1'b0} >= {1'b0, den_d});
   assign dq      = {1'b0, quo_d} + (NW+1)'(rnd);
   assign div_sat = fpa_pkg::sat32(side_d.neg ? -$signed(64'(dq)) : $signed(64'(dq)));

   always_comb begin
      value_in = side_d.value;
      st_in    = side_d.st;
      case (side_d.op)
         fpa_pkg::OP_MUL: begin
            value_in = mul_sat.value;
            st_in    = mul_sat.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
         end
         fpa_pkg::OP_DIV: begin
            if (side_d.dz) begin
               value_in = '0;
               st_in    = fpa_pkg::ST_DZ;
            end else begin
               value_in = div_sat.value;
               st_in    = div_sat.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
            end
         end
         default: begin
            value_in = side_d.value;
            st_in    = side_d.st;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         value_ff <= value_in;
         cmp_ff   <= side_d.cmp;
         st_ff    <= st_in;
      end
   end

endmodule

// ===== hw/rtl/fixed_point_alu_top.sv =====
`timescale 1ns / 1ps

// Fixed-point ALU on signed 32-bit raw values with FRACTION_BITS fraction
// bits. One word enters per cycle and one result word leaves per cycle
// while the output is not stalled; each word passes FRACTION_BITS + 34
// register stages (one prep stage, one divide cell per quotient bit,
// 32 + FRACTION_BITS of them, and one rounding stage). Every opcode
// passes the whole divide cell chain, so results leave in order. Each
// stage moves on whenever the stage after it is empty or moving, so gaps
// close up under a stalled output.
module fixed_point_alu_top #(
   parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_opcode,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_value,
   output logic               rsp_compare_true,
   output logic [1:0]         rsp_status
);

   localparam int NW  = 32 + FRACTION_BITS;
   localparam int NST = NW + 2;

   logic [NST-1:0]    stg_valid_ff;
   logic [NST:0]      rdy;
   logic [NST-1:0]    vin;

   fpa_pkg::side_type side_s [0:NW];
   logic [NW-1:0]     num_s  [0:NW];
   logic [31:0]       den_s  [0:NW];
   logic [31:0]       rem_s  [0:NW];
   logic [NW-1:0]     quo_s  [0:NW];
   logic [31:0]       value_w;

   // ready runs back from the output; a stage takes a word when it is empty or its word moves on
   assign rdy[NST] = !rsp_stall;
   assign vin[0]   = req_valid;
   genvar gi;
   generate
      for (gi = 0; gi < NST; gi++) begin : g_ctl
         assign rdy[gi] = !stg_valid_ff[gi] || rdy[gi+1];
         if (gi > 0) begin : g_vin
            assign vin[gi] = stg_valid_ff[gi-1];
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= '0;
      end else begin
         for (int i = 0; i < NST; i++) begin
            if (rdy[i]) begin
               stg_valid_ff[i] <= vin[i];
            end
         end
      end
   end

   fpa_prep #(.FRACTION_BITS(FRACTION_BITS), .NW(NW)) u_prep (
      .clock     (clock),
      .en        (rdy[0] && vin[0]),
      .opcode    (req_opcode),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .side_ff   (side_s[0]),
      .num_ff    (num_s[0]),
      .den_ff    (den_s[0])
   );

   assign rem_s[0] = '0;
   assign quo_s[0] = '0;

   // one quotient bit per cell, most significant first
   generate
      for (gi = 1; gi <= NW; gi++) begin : g_cell
         fpa_div_cell #(.NW(NW), .IDX(gi-1)) u_cell (
            .clock   (clock),
            .en      (rdy[gi] && vin[gi]),
            .side_d  (side_s[gi-1]),
            .num_d   (num_s[gi-1]),
            .den_d   (den_s[gi-1]),
            .rem_d   (rem_s[gi-1]),
            .quo_d   (quo_s[gi-1]),
            .side_ff (side_s[gi]),
            .num_ff  (num_s[gi]),
            .den_ff  (den_s[gi]),
            .rem_ff  (rem_s[gi]),
            .quo_ff  (quo_s[gi])
         );
      end
   endgenerate

   fpa_final #(.FRACTION_BITS(FRACTION_BITS), .NW(NW)) u_final (
      .clock    (clock),
      .en       (rdy[NST-1] && vin[NST-1]),
      .side_d   (side_s[NW]),
      .den_d    (den_s[NW]),
      .rem_d    (rem_s[NW]),
      .quo_d    (quo_s[NW]),
      .value_ff (value_w),
      .cmp_ff   (rsp_compare_true),
      .st_ff    (rsp_status)
   );

   assign rsp_result_value = $signed(value_w);
   assign rsp_valid        = stg_valid_ff[NST-1];
   assign req_stall        = !rdy[0];

`ifndef SYNTH
   a_cmp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_true |-> rsp_result_value == 32'sd0
                                       && rsp_status == fpa_pkg::ST_OK)
      else $error("comparison result carries a value or status");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == fpa_pkg::ST_DZ |-> rsp_result_value == 32'sd0)
      else $error("divide by zero result is not zero");

   a_prep_hold: assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff[0] && !rdy[1] |=> stg_valid_ff[0])
      else $error("blocked prep stage lost its word");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int FB = fpa_pkg::FRACTION_BITS_DEF;
   localparam int LATENCY = FB + 34;
   localparam longint CYCLE_LIMIT = 400000;
   localparam longint HI32 = 64'sd2147483647;
   localparam longint LO32 = -64'sd2147483648;

   typedef struct {
      fpa_pkg::op_type    op;
      logic signed [31:0] a;
      logic signed [31:0] b;
   } op_word_type;

   typedef struct {
      logic signed [31:0]  value;
      logic                cmp;
      fpa_pkg::status_type st;
   } alu_out_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [3:0]         req_opcode;
   logic signed [31:0] req_operand_a;
   logic signed [31:0] req_operand_b;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_result_value;
   logic               rsp_compare_true;
   logic [1:0]         rsp_status;
   logic               req_stall_ff;

   op_word_type pending_ops[$];
   alu_out_type expected_results[$];
   int          send_idle_pct;
   int          stall_pct;
   bit          stim_done;
   int          error_count;
   longint      cycle_count;

   fixed_point_alu_top #(.FRACTION_BITS(FB)) dut (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // saturate a wide value to 32 bits
   function automatic alu_out_type clamp_result(longint v);
      alu_out_type r;
      r.cmp = 1'b0;
      r.st = fpa_pkg::ST_OK;
      if (v > HI32) begin
         r.value = HI32[31:0];
         r.st = fpa_pkg::ST_OVF;
      end else if (v < LO32) begin
         r.value = LO32[31:0];
         r.st = fpa_pkg::ST_OVF;
      end else begin
         r.value = v[31:0];
      end
      return r;
   endfunction

   // exact fixed-point result of one operation
   function automatic alu_out_type alu_predict(op_word_type w);
      alu_out_type r;
      longint a, b, p, m, md, q;
      bit neg;
      a = w.a;
      b = w.b;
      r.value = '0;
      r.cmp = 1'b0;
      r.st = fpa_pkg::ST_OK;
      case (w.op)
         fpa_pkg::OP_ADD: r = clamp_result(a + b);
         fpa_pkg::OP_SUB: r = clamp_result(a - b);
         fpa_pkg::OP_MUL: begin
            p = a * b;
            neg = p < 0;
            m = neg ? -p : p;
            q = (m + ((64'sd1 << FB) >>> 1)) >>> FB;
            r = clamp_result(neg ? -q : q);
         end
         fpa_pkg::OP_DIV: begin
            if (b == 0) begin
               r.st = fpa_pkg::ST_DZ;
            end else begin
               p = a * (64'sd1 << FB);
               neg = (p < 0) != (b < 0);
               m = p < 0 ? -p : p;
               md = b < 0 ? -b : b;
               q = (2 * m + md) / (2 * md);
               r = clamp_result(neg ? -q : q);
            end
         end
         fpa_pkg::OP_GT: r.cmp = a > b;
         fpa_pkg::OP_GE: r.cmp = a >= b;
         fpa_pkg::OP_LT: r.cmp = a < b;
         fpa_pkg::OP_LE: r.cmp = a <= b;
         fpa_pkg::OP_EQ: r.cmp = a == b;
         fpa_pkg::OP_NE: r.cmp = a != b;
         fpa_pkg::OP_MIN: r.value = a < b ? w.a : w.b;
         fpa_pkg::OP_MAX: r.value = a > b ? w.a : w.b;
         fpa_pkg::OP_INC: r = clamp_result(a + 1);
         fpa_pkg::OP_DEC: r = clamp_result(a - 1);
         fpa_pkg::OP_FROM_INT: r = clamp_result(a * (64'sd1 << FB));
         default: r.value = w.a >>> FB;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] rand_operand();
      logic signed [31:0] v;
      case ($urandom_range(0, 5))
         0: v = 32'sh7FFF_FFFF - $urandom_range(0, 3);
         1: v = 32'sh8000_0000 + $urandom_range(0, 3);
         2: v = $signed($urandom_range(0, 2047)) - 1024;
         3: v = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic queue_op(fpa_pkg::op_type op, logic signed [31:0] a,
                           logic signed [31:0] b);
      op_word_type w;
      w.op = op;
      w.a = a;
      w.b = b;
      pending_ops.push_back(w);
   endtask

   task automatic drain_phase();
      while (pending_ops.size() != 0 || req_valid) @(posedge clock);
   endtask

   // stimulus: directed words, then random words over idling and stalling phases
   initial begin
      int n;
      op_word_type w;
      reset = 1'b1;
      stim_done = 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int i = 0; i < 16; i++) begin
         queue_op(fpa_pkg::op_type'(i), 32'sh7FFF_FFFF, 32'sh8000_0000);
      end
      queue_op(fpa_pkg::OP_DIV, 32'sh0000_0100, 32'sh0);
      queue_op(fpa_pkg::OP_DIV, 32'sh8000_0000, 32'sh0000_0001);
      queue_op(fpa_pkg::OP_MUL, 32'sh0000_0180, 32'shFFFF_FF80);
      queue_op(fpa_pkg::OP_MUL, 32'sh8000_0000, 32'sh8000_0000);
      queue_op(fpa_pkg::OP_INC, 32'sh7FFF_FFFF, 32'sh0);
      queue_op(fpa_pkg::OP_DEC, 32'sh8000_0000, 32'sh0);
      queue_op(fpa_pkg::OP_TO_INT, 32'shFFFF_FFFF, 32'sh0);
      queue_op(fpa_pkg::OP_EQ, 32'sh1234, 32'sh1234);
      queue_op(fpa_pkg::OP_FROM_INT, 32'shFF80_0000, 32'sh0);
      drain_phase();
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 81; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 81; end
            default: begin send_idle_pct = 32; stall_pct = 32; end
         endcase
         for (n = 0; n < 250; n++) begin
            w.op = fpa_pkg::op_type'($urandom_range(0, 15));
            w.a = rand_operand();
            w.b = ($urandom_range(0, 15) == 0) ? 32'sh0 : rand_operand();
            if ($urandom_range(0, 7) == 0) w.b = w.a;
            pending_ops.push_back(w);
         end
         drain_phase();
      end
      stim_done = 1'b1;
   end

   // driver: present words at the falling edge, hold while stalled
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_opcode <= '0;
         req_operand_a <= '0;
         req_operand_b <= '0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         if (!req_valid || !req_stall_ff) begin
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_opcode <= pending_ops[0].op;
               req_operand_a <= pending_ops[0].a;
               req_operand_b <= pending_ops[0].b;
               void'(pending_ops.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // remember stall as sampled at the rising edge
   always @(posedge clock) begin
      req_stall_ff <= req_stall;
   end

   // monitor: predict on accepted words, check accepted results
   always @(posedge clock) begin
      op_word_type w;
      alu_out_type exp_r;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            w.op = fpa_pkg::op_type'(req_opcode);
            w.a = req_operand_a;
            w.b = req_operand_b;
            expected_results.push_back(alu_predict(w));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t unexpected result value %h", $time, rsp_result_value);
               error_count++;
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_result_value !== exp_r.value || rsp_compare_true !== exp_r.cmp
                   || rsp_status !== exp_r.st) begin
                  $display("%0t mismatch: expected value %h cmp %b status %0d, got %h %b %0d",
                     $time, exp_r.value, exp_r.cmp, exp_r.st, rsp_result_value,
                     rsp_compare_true, rsp_status);
                  error_count++;
               end
            end
         end
      end
   end

   // end of run and timeout
   initial begin
      error_count = 0;
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
         if (stim_done && expected_results.size() == 0) begin
            repeat (LATENCY + 10) @(posedge clock);
            if (error_count == 0 && expected_results.size() == 0) begin
               $display("simulation ok");
            end else begin
               $display("simulation failed");
            end
            $finish;
         end
      end
   end

endmodule
